@@ rtl/core/tqpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tqpi_pkg
// shared types and constants for the ticket queue with priority insert
// ----------------------------------------------------------------------------
package tqpi_pkg;

	localparam int TQ_DEPTH = 16;
	localparam int ID_W     = 32;
	localparam int TICKET_W = 16;

	localparam logic [TICKET_W-1:0] TICKET_START = TICKET_W'(1);

	typedef enum logic [1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP        = 2'd2,
		CMD_LIST       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_QUEUED = 3'd0,
		STAT_POPPED = 3'd1,
		STAT_EMPTY  = 3'd2,
		STAT_FULL   = 3'd3,
		STAT_LIST   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_LIST
	} state_t;

	// one command transaction
	typedef struct packed {
		cmd_t              command;
		logic [ID_W-1:0]   patient_id;
	} req_t;

	// one result transaction
	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     out_id;
		logic [TICKET_W-1:0] ticket;
		logic                last;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    push;
		logic    rd_start;
		logic    rd_step;
		logic    pop_commit;
		logic    emit;
		status_t emit_status;
		logic    emit_last;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic list_last;
	} sts_t;

endpackage

@@ rtl/core/tqpi_ctrl.sv @@
// ----------------------------------------------------------------------------
// tqpi_ctrl
// command sequencer: decodes the latched command and steps pop and list reads
// ----------------------------------------------------------------------------
module tqpi_ctrl
	import tqpi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ctl             = '0;
		ctl.emit_status = STAT_EMPTY;
		busy            = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.cmd)
					CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
						ctl.emit      = 1'b1;
						ctl.emit_last = 1'b1;
						if (sts.full) begin
							ctl.emit_status = STAT_FULL;
						end else begin
							ctl.push        = 1'b1;
							ctl.emit_status = STAT_QUEUED;
						end
						state_d = S_IDLE;
					end
					CMD_POP, CMD_LIST: begin
						if (sts.empty) begin
							ctl.emit        = 1'b1;
							ctl.emit_last   = 1'b1;
							ctl.emit_status = STAT_EMPTY;
							state_d         = S_IDLE;
						end else begin
							ctl.rd_start = 1'b1;
							state_d      = (sts.cmd == CMD_POP) ? S_POP : S_LIST;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				ctl.emit        = 1'b1;
				ctl.emit_last   = 1'b1;
				ctl.emit_status = STAT_POPPED;
				ctl.pop_commit  = 1'b1;
				state_d         = S_IDLE;
			end
			S_LIST: begin
				ctl.emit        = 1'b1;
				ctl.emit_status = STAT_LIST;
				ctl.emit_last   = sts.list_last;
				if (sts.list_last) begin
					state_d = S_IDLE;
				end else begin
					ctl.rd_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/tqpi_dpath.sv @@
// ----------------------------------------------------------------------------
// tqpi_dpath
// ring storage, head and count registers, ticket counter and result register
// ----------------------------------------------------------------------------
module tqpi_dpath
	import tqpi_pkg::*;
#(
	parameter int DEPTH = TQ_DEPTH
)
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output sts_t sts,
	output rsp_t rsp,
	output logic rsp_strobe
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// ring memory
	logic [ID_W-1:0]     id_store     [DEPTH];
	logic [TICKET_W-1:0] ticket_store [DEPTH];

	req_t                req_q;
	logic [IW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [TICKET_W-1:0] next_ticket_q;
	logic [IW-1:0]       list_ptr_q;
	logic [CW-1:0]       list_rem_q;
	logic [ID_W-1:0]     rd_id_q;
	logic [TICKET_W-1:0] rd_ticket_q;
	rsp_t                rsp_q;
	logic                strobe_q;

	logic [IW:0]   tail_sum;
	logic [IW-1:0] tail_slot;
	logic [IW-1:0] head_dec;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] list_inc;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic          rd_en;

	// tail slot = (head + count) mod depth, sum stays below twice the depth
	always_comb begin
		tail_sum  = {1'b0, head_q} + {1'b0, count_q[IW-1:0]};
		tail_slot = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : tail_sum[IW-1:0];
		head_dec  = (head_q == '0) ? LAST_SLOT : head_q - IW'(1);
		head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + IW'(1);
		list_inc  = (list_ptr_q == LAST_SLOT) ? '0 : list_ptr_q + IW'(1);
		wr_addr   = (req_q.command == CMD_PUSH_FRONT) ? head_dec : tail_slot;
		rd_en     = ctl.rd_start | ctl.rd_step;
		rd_addr   = ctl.rd_step ? list_inc : head_q;
	end

	always_comb begin
		sts.cmd       = req_q.command;
		sts.empty     = (count_q == '0);
		sts.full      = (count_q >= DEPTH_C);
		sts.list_last = (list_rem_q == CW'(1));
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			id_store[wr_addr]     <= req_q.patient_id;
			ticket_store[wr_addr] <= next_ticket_q;
		end
		if (rd_en) begin
			rd_id_q     <= id_store[rd_addr];
			rd_ticket_q <= ticket_store[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (rd_en) begin
			list_ptr_q <= rd_addr;
		end
		if (ctl.rd_start) begin
			list_rem_q <= count_q;
		end else if (ctl.rd_step) begin
			list_rem_q <= list_rem_q - CW'(1);
		end
		if (ctl.emit) begin
			rsp_q.status <= ctl.emit_status;
			rsp_q.last   <= ctl.emit_last;
			case (ctl.emit_status)
				STAT_QUEUED: begin
					rsp_q.out_id <= req_q.patient_id;
					rsp_q.ticket <= next_ticket_q;
				end
				STAT_POPPED, STAT_LIST: begin
					rsp_q.out_id <= rd_id_q;
					rsp_q.ticket <= rd_ticket_q;
				end
				default: begin
					rsp_q.out_id <= '0;
					rsp_q.ticket <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			next_ticket_q <= TICKET_START;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
			if (ctl.push) begin
				count_q       <= count_q + CW'(1);
				next_ticket_q <= next_ticket_q + TICKET_W'(1);
				if (req_q.command == CMD_PUSH_FRONT) begin
					head_q <= head_dec;
				end
			end else if (ctl.pop_commit) begin
				count_q <= count_q - CW'(1);
				head_q  <= head_inc;
			end
		end
	end

	assign rsp        = rsp_q;
	assign rsp_strobe = strobe_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_SLOT)
		else $error("head index outside ring");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !sts.full)
		else $error("push into full ring");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_commit |-> !sts.empty)
		else $error("pop from empty ring");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> (count_q == $past(count_q) + CW'(1)) && strobe_q)
		else $error("push did not grow queue or report");

endmodule

@@ rtl/core/ticket_queue_with_priority_insert.sv @@
// ----------------------------------------------------------------------------
// ticket_queue_with_priority_insert
// bounded ring queue that hands out ticket numbers, with head insert, pop
// and a walk over all waiting entries
// ----------------------------------------------------------------------------
//
// channel   ports                 handshake
// --------  --------------------  ------------------------------------------
// command   req (req_t)           taken when start && !busy
// result    rsp (rsp_t)           valid for one cycle while rsp_strobe is high
//
// - a push or an empty pop or list passes the command and result registers;
//   busy drops the cycle the result shows, so a new command is taken only
//   once the previous result is out
// - a pop also passes the registered read port of the ring memory
// - a list of n entries gives its n results back to back, one ring read each
// - reset clears head, count and the ticket counter (back to 1); the ring
//   memory is not cleared, only slots holding waiting entries are ever read
// - results cannot be stalled: each result transaction is taken in its cycle
//
module ticket_queue_with_priority_insert
	import tqpi_pkg::*;
#(
	parameter int DEPTH = TQ_DEPTH
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output rsp_t rsp,
	output logic rsp_strobe
);

	// controller and datapath talk only through these two groups
	ctl_t ctl;
	sts_t sts;

	// sequencer: idle, decode, pop read wait, list walk
	tqpi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// ring memory, pointers, ticket counter and result register
	tqpi_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.ctl        (ctl),
		.sts        (sts),
		.rsp        (rsp),
		.rsp_strobe (rsp_strobe)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ticket queue with priority insert: a directed
// table (empty, full, head insert, id extremes) then random command traffic
// under several sender idle patterns, every result transaction checked
// against a cycle-free mirror of the queue
// ----------------------------------------------------------------------------
module tb_top;
	import tqpi_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 24;   // a full list plus its lead-in
	localparam int SHOW_ERRS   = 10;
	localparam int PHASE_ITEMS = 51;

	// one row of the directed table
	typedef struct {
		cmd_t              cmd;
		logic [ID_W-1:0]   id;
		int                reps;   // repeats with id counting up
		bit                typed;  // want holds the result to see
		rsp_t              want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	rsp_t rsp;
	logic rsp_strobe;

	// typed expectation travels alongside the command transaction
	logic want_on;
	rsp_t want_rsp;

	// mirror of the queue contents, updated on each accepted command
	logic [ID_W-1:0]     mirror_id [TQ_DEPTH];
	logic [TICKET_W-1:0] mirror_tk [TQ_DEPTH];
	int                  mirror_head;
	int                  mirror_count;
	logic [TICKET_W-1:0] mirror_next_ticket;

	// result transactions still owed by the block, oldest first
	rsp_t awaited_rsp [$];
	stim_row_t directed_rows [$];

	int err_count;
	int cycle_count;
	int n_push, n_pop, n_list;
	int n_results, n_full, n_empty, n_ticket_zero;

	ticket_queue_with_priority_insert i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.rsp        (rsp),
		.rsp_strobe (rsp_strobe)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic rsp_t mk_rsp(status_t s, logic [ID_W-1:0] id,
	                                logic [TICKET_W-1:0] tk, logic l);
		rsp_t r;
		r.status = s;
		r.out_id = id;
		r.ticket = tk;
		r.last   = l;
		return r;
	endfunction

	// work out every result one command transaction causes
	task automatic model_command(input req_t c);
		int s;
		int n;
		case (c.command)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (mirror_count >= TQ_DEPTH) begin
					// ring full: no ticket used, queue untouched
					awaited_rsp.push_back(mk_rsp(STAT_FULL, '0, '0, 1'b1));
				end else begin
					if (c.command == CMD_PUSH_BACK) begin
						s = (mirror_head + mirror_count) % TQ_DEPTH;
					end else begin
						mirror_head = (mirror_head + TQ_DEPTH - 1) % TQ_DEPTH;
						s = mirror_head;
					end
					mirror_id[s] = c.patient_id;
					mirror_tk[s] = mirror_next_ticket;
					mirror_count++;
					awaited_rsp.push_back(mk_rsp(STAT_QUEUED, c.patient_id,
					                             mirror_next_ticket, 1'b1));
					mirror_next_ticket = mirror_next_ticket + 1'b1;  // wraps at 16 bits
				end
			end
			CMD_POP: begin
				if (mirror_count == 0) begin
					awaited_rsp.push_back(mk_rsp(STAT_EMPTY, '0, '0, 1'b1));
				end else begin
					awaited_rsp.push_back(mk_rsp(STAT_POPPED, mirror_id[mirror_head],
					                             mirror_tk[mirror_head], 1'b1));
					mirror_head = (mirror_head + 1) % TQ_DEPTH;
					mirror_count--;
				end
			end
			default: begin
				// list walks head to tail, last flag on the final entry only
				if (mirror_count == 0) begin
					awaited_rsp.push_back(mk_rsp(STAT_EMPTY, '0, '0, 1'b1));
				end else begin
					for (n = 0; n < mirror_count; n++) begin
						s = (mirror_head + n) % TQ_DEPTH;
						awaited_rsp.push_back(mk_rsp(STAT_LIST, mirror_id[s], mirror_tk[s],
						                             n == mirror_count - 1));
					end
				end
			end
		endcase
	endtask

	// compare one result transaction with the oldest one owed
	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (awaited_rsp.size() == 0) begin
			err_count++;
			if (err_count <= SHOW_ERRS)
				$display("[%0t] unexpected result: ", $realtime,
				         "status %0d id %h ticket %0d last %0b",
				         got.status, got.out_id, got.ticket, got.last);
		end else begin
			want = awaited_rsp.pop_front();
			n_results++;
			if (want.status == STAT_FULL)
				n_full++;
			if (want.status == STAT_EMPTY)
				n_empty++;
			if (want.status == STAT_QUEUED && want.ticket == '0)
				n_ticket_zero++;
			if (got.status !== want.status || got.out_id !== want.out_id ||
			    got.ticket !== want.ticket || got.last !== want.last) begin
				err_count++;
				if (err_count <= SHOW_ERRS)
					$display("[%0t] mismatch: ", $realtime,
					         "exp status %0d id %h ticket %0d last %0b, ",
					         want.status, want.out_id, want.ticket, want.last,
					         "got status %0d id %h ticket %0d last %0b",
					         got.status, got.out_id, got.ticket, got.last);
			end
		end
	endtask

	// monitor: results first, then the command transaction taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_strobe)
				check_result(rsp);
			if (start && !busy) begin
				case (req.command)
					CMD_PUSH_BACK, CMD_PUSH_FRONT: n_push++;
					CMD_POP: n_pop++;
					default: n_list++;
				endcase
				model_command(req);
				// typed rows are single-result commands, swap in the typed value
				if (want_on) begin
					void'(awaited_rsp.pop_back());
					awaited_rsp.push_back(want_rsp);
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still owed",
		         cycle_count, awaited_rsp.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// present one command and hold it until the block takes it
	task automatic issue(input cmd_t c, input logic [ID_W-1:0] id, input bit typed,
	                     input rsp_t want);
		start    <= 1'b1;
		req      <= {c, id};
		want_on  <= typed;
		want_rsp <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// per-cycle idle chance, junk on req while start is low
	task automatic idle_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start   <= 1'b0;
			req     <= {cmd_t'($urandom_range(3)), ID_W'($urandom)};
			want_on <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < pct)
				@(posedge clk);
		end
	endtask

	// hold off until every owed result has come back
	task automatic drain_wait();
		start   <= 1'b0;
		want_on <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	// random commands, biased toward filling or draining by push_pct
	task automatic random_phase(input int n, input int idle_pct, input int push_pct);
		int k;
		int r;
		cmd_t c;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < push_pct)
				c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else if (r < push_pct + 15)
				c = CMD_LIST;
			else
				c = CMD_POP;
			issue(c, ID_W'($urandom), 1'b0, '0);
			idle_gap(idle_pct);
		end
		drain_wait();
	endtask

	function automatic void add_row(cmd_t c, logic [ID_W-1:0] id, int reps, bit typed,
	                                rsp_t want);
		stim_row_t row;
		row.cmd   = c;
		row.id    = id;
		row.reps  = reps;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	initial begin
		int k;

		// every input known from time zero
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		want_on  = 1'b0;
		want_rsp = '0;

		err_count          = 0;
		n_push             = 0;
		n_pop              = 0;
		n_list             = 0;
		n_results          = 0;
		n_full             = 0;
		n_empty            = 0;
		n_ticket_zero      = 0;
		mirror_head        = 0;
		mirror_count       = 0;
		mirror_next_ticket = TICKET_START;
		for (k = 0; k < TQ_DEPTH; k++) begin
			mirror_id[k] = '0;
			mirror_tk[k] = '0;
		end

		// directed table: empty queue, head insert into empty, id extremes,
		// fill to the brim, push into a full ring, list of a full ring
		add_row(CMD_POP,        '0, 1, 1'b1, mk_rsp(STAT_EMPTY, '0, '0, 1'b1));
		add_row(CMD_LIST,       '1, 1, 1'b1, mk_rsp(STAT_EMPTY, '0, '0, 1'b1));
		add_row(CMD_PUSH_FRONT, '0, 1, 1'b1, mk_rsp(STAT_QUEUED, '0, 16'd1, 1'b1));
		add_row(CMD_PUSH_BACK,  '1, 1, 1'b1, mk_rsp(STAT_QUEUED, '1, 16'd2, 1'b1));
		add_row(CMD_POP,        '1, 1, 1'b1, mk_rsp(STAT_POPPED, '0, 16'd1, 1'b1));
		add_row(CMD_POP,        '0, 1, 1'b1, mk_rsp(STAT_POPPED, '1, 16'd2, 1'b1));
		add_row(CMD_POP,        '0, 1, 1'b1, mk_rsp(STAT_EMPTY, '0, '0, 1'b1));
		add_row(CMD_PUSH_BACK,  32'hA5A5_0000, TQ_DEPTH / 2, 1'b0, '0);
		add_row(CMD_PUSH_FRONT, 32'h5A5A_FFF0, TQ_DEPTH / 2, 1'b0, '0);
		add_row(CMD_PUSH_BACK,  '1, 1, 1'b1, mk_rsp(STAT_FULL, '0, '0, 1'b1));
		add_row(CMD_LIST,       '0, 1, 1'b0, '0);

		// reset held low from time zero, released on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			for (k = 0; k < directed_rows[i].reps; k++)
				issue(directed_rows[i].cmd, directed_rows[i].id + k,
				      directed_rows[i].typed, directed_rows[i].want);
		drain_wait();

		// random traffic: back to back, mostly idle, partly idle, back to back again
		random_phase(PHASE_ITEMS, 0, 60);
		random_phase(PHASE_ITEMS, 86, 30);
		random_phase(PHASE_ITEMS, 32, 45);
		random_phase(PHASE_ITEMS, 0, 50);

		// let any stray result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d commands (%0d push, %0d pop, %0d list), ",
		         n_push + n_pop + n_list, n_push, n_pop, n_list,
		         "%0d results checked", n_results);
		$display("full ring hits %0d, empty hits %0d, ", n_full, n_empty,
		         "ticket zero handed out %0d times, %0d mismatches",
		         n_ticket_zero, err_count);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/tqpi_pkg.sv
rtl/core/tqpi_ctrl.sv
rtl/core/tqpi_dpath.sv
rtl/core/ticket_queue_with_priority_insert.sv
test/tb_top.sv
